### rtl/core/fst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, constants and tables for the frame sequence tracker: the
// verdict codes, the counter record, the pipeline stage records and the
// residue table used for the whole-millisecond test.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int SEQ_W  = 64;
  localparam int TIME_W = 64;
  localparam int CNT_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // One millisecond in ns splits into 2^6 and an odd factor of 15625
  localparam int MS_NS        = 1000000;
  localparam int MS_POW2_BITS = 6;
  localparam int MS_ODD       = MS_NS / (1 << MS_POW2_BITS);
  localparam int RES_W        = $clog2(MS_ODD);

  // Odd part of the magnitude is taken apart in byte-wide chunks
  localparam int CHUNK_W    = 8;
  localparam int N_CHUNKS   = 8;
  localparam int N_PAIRS    = N_CHUNKS / 2;
  localparam int CHUNK_VALS = 1 << CHUNK_W;
  localparam int ODD_EXT_W  = N_CHUNKS * CHUNK_W;
  localparam int PAIR_W     = RES_W + 1;
  localparam int SUM_W      = RES_W + 3;
  localparam int N_MULT     = 1 << (SUM_W - RES_W);

  typedef enum logic [1:0] {
    VERDICT_DELIVERED  = 2'd0,
    VERDICT_MALFORMED  = 2'd1,
    VERDICT_UNVERIFIED = 2'd2,
    VERDICT_STALE      = 2'd3
  } verdict_t;

  typedef logic [N_CHUNKS-1:0][CHUNK_VALS-1:0][RES_W-1:0] mod_tab_t;

  typedef struct packed {
    logic [CNT_W-1:0] delivered;
    logic [CNT_W-1:0] stale;
    logic [CNT_W-1:0] malformed;
    logic [CNT_W-1:0] unverified;
    logic [CNT_W-1:0] resets;
    logic [CNT_W-1:0] gaps;
  } cnt_t;

  // Classified item, after the sequence check
  typedef struct packed {
    verdict_t          verdict;
    logic              session_start;
    logic              is_reset;
    logic [SEQ_W-1:0]  missing;
    logic              backward;
    logic [TIME_W-1:0] mag;
  } cls_t;

  // Item with partial residues and updated totals
  typedef struct packed {
    verdict_t                       verdict;
    logic                           session_start;
    logic                           is_reset;
    logic [SEQ_W-1:0]               missing;
    logic                           backward;
    logic                           low_zero;
    logic [N_PAIRS-1:0][PAIR_W-1:0] part;
    cnt_t                           cnt;
  } res_stage_t;

  // Finished result
  typedef struct packed {
    verdict_t         verdict;
    logic             session_start;
    logic             is_reset;
    logic [SEQ_W-1:0] missing;
    logic             not_whole_ms;
    logic             backward;
    cnt_t             cnt;
  } result_t;

  // Entry [c][v] holds (v * 256^c) mod MS_ODD
  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    int       weight;
    tab    = '0;
    weight = 1;
    for (int c = 0; c < N_CHUNKS; c++) begin
      for (int v = 0; v < CHUNK_VALS; v++) begin
        tab[c][v] = RES_W'((v * weight) % MS_ODD);
      end
      weight = (weight * CHUNK_VALS) % MS_ODD;
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // Saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    return (a == CNT_MAX) ? a : a + CNT_W'(1);
  endfunction

  // Saturating add of a wide amount into a total
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
    logic over;
    over = (b[SEQ_W-1:CNT_W] != '0) || (b[CNT_W-1:0] >= ~a);
    return over ? CNT_MAX : a + b[CNT_W-1:0];
  endfunction

endpackage

### rtl/core/frame_sequence_tracker_core.sv
`timescale 1ns / 1ps
// Each accepted item passes in order through the input register and the
// classify, residue and result stages. Throughput: one item per cycle while
// result_stall is low; each stage holds one item and moves on independently.
// Reset (synchronous): closes the session, zeroes stored sequence, time and
// all totals, and empties every stage.
// ----------------------------------------------------------------------------
// frame_sequence_tracker_core
// Classifies parsed frame headers as delivered, malformed, unverified or
// stale, tracks sequence gaps and resets, flags timing anomalies and keeps
// saturating totals.
// ----------------------------------------------------------------------------
module frame_sequence_tracker_core
  import fst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     frame_valid,
  output logic                     frame_stall,
  input  logic                     frame_ok,
  input  logic                     payload_ok,
  input  logic [SEQ_W-1:0]         seq,
  input  logic signed [TIME_W-1:0] sample_time_ns,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [1:0]               verdict,
  output logic                     session_start,
  output logic                     is_reset,
  output logic [SEQ_W-1:0]         missing_frames,
  output logic                     not_whole_ms,
  output logic                     time_backward,
  output logic [CNT_W-1:0]         delivered_count,
  output logic [CNT_W-1:0]         stale_count,
  output logic [CNT_W-1:0]         malformed_count,
  output logic [CNT_W-1:0]         unverified_count,
  output logic [CNT_W-1:0]         reset_count,
  output logic [CNT_W-1:0]         gap_total
);

  // Stage valids and load enables
  logic s1_valid, s2_valid, s3_valid;
  logic ld1, ld2, ld3, ld_out;

  // Input register
  logic                     f_frame_ok;
  logic                     f_payload_ok;
  logic [SEQ_W-1:0]         f_seq;
  logic signed [TIME_W-1:0] f_time;

  // Session state
  logic                     have_session;
  logic [SEQ_W-1:0]         last_sequence;
  logic signed [TIME_W-1:0] last_time;
  cnt_t                     cnt;
  cnt_t                     cnt_next;

  cls_t       s2, s2_next;
  res_stage_t s3, s3_next;
  result_t    res, res_next;

  logic [SEQ_W-1:0]     seq_expect;
  logic [ODD_EXT_W-1:0] odd_ext;
  logic [SUM_W-1:0]     res_sum;
  logic                 is_multiple;

  // Each stage takes a new item when empty or when its item moves on
  assign ld_out      = !result_valid || !result_stall;
  assign ld3         = !s3_valid || ld_out;
  assign ld2         = !s2_valid || ld3;
  assign ld1         = !s1_valid || ld2;
  assign frame_stall = !ld1;

  // Classify against the stored session
  assign seq_expect = last_sequence + SEQ_W'(1);

  always_comb begin
    s2_next               = '0;
    s2_next.mag           = f_time[TIME_W-1] ? TIME_W'(-f_time) : TIME_W'(f_time);
    s2_next.verdict       = VERDICT_DELIVERED;
    if (!f_frame_ok) begin
      s2_next.verdict = VERDICT_MALFORMED;
    end else if (!f_payload_ok) begin
      s2_next.verdict = VERDICT_UNVERIFIED;
    end else if (!have_session) begin
      s2_next.session_start = 1'b1;
    end else if (f_seq == seq_expect) begin
      s2_next.session_start = 1'b0;
    end else if (f_seq == '0 && last_sequence != '0) begin
      s2_next.session_start = 1'b1;
      s2_next.is_reset      = 1'b1;
    end else if (f_seq > seq_expect) begin
      s2_next.missing = f_seq - seq_expect;
    end else begin
      s2_next.verdict = VERDICT_STALE;
    end
    s2_next.backward = (s2_next.verdict == VERDICT_DELIVERED) &&
                       !s2_next.session_start && (f_time < last_time);
  end

  // Update totals and look up residues of the odd part of the magnitude
  assign odd_ext = ODD_EXT_W'(s2.mag[TIME_W-1:MS_POW2_BITS]);

  always_comb begin
    cnt_next = cnt;
    case (s2.verdict)
      VERDICT_DELIVERED:  cnt_next.delivered  = sat_inc(cnt.delivered);
      VERDICT_MALFORMED:  cnt_next.malformed  = sat_inc(cnt.malformed);
      VERDICT_UNVERIFIED: cnt_next.unverified = sat_inc(cnt.unverified);
      VERDICT_STALE:      cnt_next.stale      = sat_inc(cnt.stale);
      default:            cnt_next.stale      = cnt.stale;
    endcase
    if (s2.is_reset) begin
      cnt_next.resets = sat_inc(cnt.resets);
    end
    cnt_next.gaps = sat_add(cnt.gaps, s2.missing);
  end

  always_comb begin
    s3_next               = '0;
    s3_next.verdict       = s2.verdict;
    s3_next.session_start = s2.session_start;
    s3_next.is_reset      = s2.is_reset;
    s3_next.missing       = s2.missing;
    s3_next.backward      = s2.backward;
    s3_next.low_zero      = (s2.mag[MS_POW2_BITS-1:0] == '0);
    s3_next.cnt           = cnt_next;
    for (int p = 0; p < N_PAIRS; p++) begin
      s3_next.part[p] =
        PAIR_W'(MOD_TAB[2*p][odd_ext[2*p*CHUNK_W +: CHUNK_W]]) +
        PAIR_W'(MOD_TAB[2*p+1][odd_ext[(2*p+1)*CHUNK_W +: CHUNK_W]]);
    end
  end

  // Fold the partial residues and test for a multiple of the odd factor
  always_comb begin
    res_sum = '0;
    for (int p = 0; p < N_PAIRS; p++) begin
      res_sum = res_sum + SUM_W'(s3.part[p]);
    end
    is_multiple = 1'b0;
    for (int k = 0; k < N_MULT; k++) begin
      if (res_sum == SUM_W'(k * MS_ODD)) begin
        is_multiple = 1'b1;
      end
    end
  end

  always_comb begin
    res_next               = '0;
    res_next.verdict       = s3.verdict;
    res_next.session_start = s3.session_start;
    res_next.is_reset      = s3.is_reset;
    res_next.missing       = s3.missing;
    res_next.backward      = s3.backward;
    res_next.not_whole_ms  = (s3.verdict == VERDICT_DELIVERED) &&
                             !(s3.low_zero && is_multiple);
    res_next.cnt           = s3.cnt;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ld1)    s1_valid     <= frame_valid;
      if (ld2)    s2_valid     <= s1_valid;
      if (ld3)    s3_valid     <= s2_valid;
      if (ld_out) result_valid <= s3_valid;
    end
  end

  // Commit session state when a delivered item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      have_session  <= 1'b0;
      last_sequence <= '0;
      last_time     <= '0;
    end else if (s1_valid && ld2 && s2_next.verdict == VERDICT_DELIVERED) begin
      have_session  <= 1'b1;
      last_sequence <= f_seq;
      last_time     <= f_time;
    end
  end

  // Commit totals when an item leaves the classify stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (s2_valid && ld3) begin
      cnt <= cnt_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ld1) begin
      f_frame_ok   <= frame_ok;
      f_payload_ok <= payload_ok;
      f_seq        <= seq;
      f_time       <= sample_time_ns;
    end
    if (ld2)    s2  <= s2_next;
    if (ld3)    s3  <= s3_next;
    if (ld_out) res <= res_next;
  end

  assign verdict          = res.verdict;
  assign session_start    = res.session_start;
  assign is_reset         = res.is_reset;
  assign missing_frames   = res.missing;
  assign not_whole_ms     = res.not_whole_ms;
  assign time_backward    = res.backward;
  assign delivered_count  = res.cnt.delivered;
  assign stale_count      = res.cnt.stale;
  assign malformed_count  = res.cnt.malformed;
  assign unverified_count = res.cnt.unverified;
  assign reset_count      = res.cnt.resets;
  assign gap_total        = res.cnt.gaps;

`ifndef SYNTHESIS
  // Dropped items carry no event flags
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && res.verdict != VERDICT_DELIVERED |->
      !session_start && !is_reset && missing_frames == '0 &&
      !not_whole_ms && !time_backward)
    else $error("dropped item carries event flags");

  // A sequence reset always opens a session
  a_reset_opens: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_reset |-> session_start)
    else $error("sequence reset without session start");

  // The delivered and gap totals never go backwards
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> cnt.delivered >= $past(cnt.delivered) &&
             cnt.gaps >= $past(cnt.gaps))
    else $error("total decreased");

  // Only delivered items move the stored sequence
  a_drop_no_commit: assert property (@(posedge clk) disable iff (rst)
    s1_valid && ld2 && s2_next.verdict != VERDICT_DELIVERED |=>
      $stable(last_sequence) && $stable(last_time))
    else $error("dropped item changed session state");
`endif

endmodule

### tb/sv/frame_sequence_tracker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sequence_tracker_core_tb
// Self-checking bench for the frame sequence tracker. Frame headers go in
// through the valid/stall input channel. A local model of the tracker works
// out each verdict, its flags and the running totals. A monitor compares
// every result, field by field, with the oldest prediction. Directed cases
// cover drops, session opening, resets, gaps, stale frames, wrap of the
// sequence number, time extremes and gap total saturation. A back-pressure
// hold and random traffic with random idling on both sides follow.
// ----------------------------------------------------------------------------
module frame_sequence_tracker_core_tb;
  import fst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = '1;
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] NS_PER_MS = 64'd1000000;

  logic                     clk;
  logic                     rst;
  logic                     frame_valid;
  logic                     frame_stall;
  logic                     frame_ok;
  logic                     payload_ok;
  logic [SEQ_W-1:0]         seq;
  logic signed [TIME_W-1:0] sample_time_ns;
  logic                     result_valid;
  logic                     result_stall;
  logic [1:0]               verdict;
  logic                     session_start;
  logic                     is_reset;
  logic [SEQ_W-1:0]         missing_frames;
  logic                     not_whole_ms;
  logic                     time_backward;
  logic [CNT_W-1:0]         delivered_count;
  logic [CNT_W-1:0]         stale_count;
  logic [CNT_W-1:0]         malformed_count;
  logic [CNT_W-1:0]         unverified_count;
  logic [CNT_W-1:0]         reset_count;
  logic [CNT_W-1:0]         gap_total;

  // Tracker model state
  logic                     model_open;
  logic [SEQ_W-1:0]         model_last_seq;
  logic signed [TIME_W-1:0] model_last_ns;
  cnt_t                     model_tally;

  result_t pending_verdicts[$];

  int  mismatches;
  int  frames_sent;
  int  results_seen;
  int  delivered_seen;
  int  session_seen;
  int  reset_seen;
  int  gap_seen;
  int  cycles;
  int  input_stall_cycles;
  int  hold_request;
  int  hold_applied;
  bit  send_steady;
  bit  recv_steady;

  frame_sequence_tracker_core u_top (
    .clk              (clk),
    .rst              (rst),
    .frame_valid      (frame_valid),
    .frame_stall      (frame_stall),
    .frame_ok         (frame_ok),
    .payload_ok       (payload_ok),
    .seq              (seq),
    .sample_time_ns   (sample_time_ns),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .verdict          (verdict),
    .session_start    (session_start),
    .is_reset         (is_reset),
    .missing_frames   (missing_frames),
    .not_whole_ms     (not_whole_ms),
    .time_backward    (time_backward),
    .delivered_count  (delivered_count),
    .stale_count      (stale_count),
    .malformed_count  (malformed_count),
    .unverified_count (unverified_count),
    .reset_count      (reset_count),
    .gap_total        (gap_total)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Saturating sum of a wide amount into a 32-bit total
  function automatic logic [CNT_W-1:0] clamp_sum(input logic [CNT_W-1:0] total,
                                                 input logic [SEQ_W-1:0] amount);
    logic [SEQ_W-1:0] room;
    room = {32'd0, CNT_MAX} - {32'd0, total};
    if (amount >= room) begin
      return CNT_MAX;
    end
    return total + amount[CNT_W-1:0];
  endfunction

  // Classify one frame and advance the model state
  function automatic result_t classify_frame(input logic fok, input logic pok,
                                             input logic [SEQ_W-1:0] s,
                                             input logic signed [TIME_W-1:0] t);
    result_t          r;
    logic [SEQ_W-1:0] next_seq;
    logic [TIME_W-1:0] mag;
    logic             deliver;
    r        = '0;
    next_seq = model_last_seq + 64'd1;
    deliver  = 1'b0;
    if (!fok) begin
      model_tally.malformed = clamp_sum(model_tally.malformed, 64'd1);
      r.verdict = VERDICT_MALFORMED;
    end else if (!pok) begin
      model_tally.unverified = clamp_sum(model_tally.unverified, 64'd1);
      r.verdict = VERDICT_UNVERIFIED;
    end else begin
      deliver = 1'b1;
      if (!model_open) begin
        r.session_start = 1'b1;
      end else if (s == next_seq) begin
        // contiguous: nothing to flag
      end else if (s == '0 && model_last_seq != '0) begin
        r.is_reset      = 1'b1;
        r.session_start = 1'b1;
        model_tally.resets = clamp_sum(model_tally.resets, 64'd1);
      end else if (s > next_seq) begin
        r.missing = s - model_last_seq - 64'd1;
        model_tally.gaps = clamp_sum(model_tally.gaps, r.missing);
      end else begin
        deliver = 1'b0;
        model_tally.stale = clamp_sum(model_tally.stale, 64'd1);
        r.verdict = VERDICT_STALE;
      end
    end
    if (deliver) begin
      mag = t[TIME_W-1] ? -t : t;
      r.verdict      = VERDICT_DELIVERED;
      r.not_whole_ms = (mag % NS_PER_MS) != '0;
      r.backward     = !r.session_start && (t < model_last_ns);
      model_tally.delivered = clamp_sum(model_tally.delivered, 64'd1);
      model_open     = 1'b1;
      model_last_seq = s;
      model_last_ns  = t;
    end
    r.cnt = model_tally;
    return r;
  endfunction

  // Offer one frame after a random gap and hold it until accepted
  task automatic offer_frame(input logic fok, input logic pok,
                             input logic [SEQ_W-1:0] s,
                             input logic signed [TIME_W-1:0] t);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid    <= 1'b1;
    frame_ok       <= fok;
    payload_ok     <= pok;
    seq            <= s;
    sample_time_ns <= t;
    do @(posedge clk); while (frame_stall !== 1'b0);
    pending_verdicts.push_back(classify_frame(fok, pok, s, t));
    frames_sent++;
  endtask

  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Drops: malformed, both flags bad, unverified
  task automatic test_drop_paths();
    offer_frame(1'b0, 1'b1, '0, '0);
    offer_frame(1'b0, 1'b0, SEQ_ALL_ONES, TIME_MIN);
    offer_frame(1'b1, 1'b0, 64'd1, 64'sd1);
    wait_drained();
  endtask

  // Session opening, duplicate zero, contiguous, reset, gap and stale frames
  task automatic test_sequence_order();
    offer_frame(1'b1, 1'b1, 64'd0, 64'sd0);
    offer_frame(1'b1, 1'b1, 64'd0, 64'sd1000000);
    offer_frame(1'b1, 1'b1, 64'd1, 64'sd2000000);
    offer_frame(1'b1, 1'b1, 64'd2, 64'sd1500000);
    offer_frame(1'b1, 1'b1, 64'd0, -64'sd3000000);
    offer_frame(1'b1, 1'b1, 64'd6, -64'sd2999999);
    offer_frame(1'b1, 1'b1, 64'd4, 64'sd5000000);
    offer_frame(1'b1, 1'b1, 64'd6, 64'sd6000000);
    wait_drained();
  endtask

  // Sequence wrap, time extremes and gap total saturation
  task automatic test_wrap_and_limits();
    offer_frame(1'b1, 1'b1, SEQ_ALL_ONES, TIME_MAX);
    offer_frame(1'b1, 1'b1, 64'd0, TIME_MIN);
    offer_frame(1'b1, 1'b1, 64'd7, -64'sd1);
    offer_frame(1'b1, 1'b1, SEQ_ALL_ONES, 64'sd9000000);
    offer_frame(1'b1, 1'b1, 64'd9, 64'sd8000000);
    wait_drained();
  endtask

  // Hold the result side off while the sender keeps offering
  task automatic test_back_pressure();
    send_steady  = 1'b1;
    hold_request = 60;
    for (int i = 0; i < 24; i++) begin
      offer_frame(1'b1, 1'b1, model_last_seq + 64'd1,
                  model_last_ns + $signed(NS_PER_MS));
    end
    send_steady = 1'b0;
    wait_drained();
  endtask

  // Mostly well-formed streams with random content, plus noise
  task automatic send_random_frames(input int count);
    int                       kind;
    int                       tkind;
    logic                     fok;
    logic                     pok;
    logic [SEQ_W-1:0]         s;
    logic signed [TIME_W-1:0] t;
    for (int i = 0; i < count; i++) begin
      kind  = $urandom_range(0, 99);
      tkind = $urandom_range(0, 99);
      fok   = 1'b1;
      pok   = 1'b1;
      s     = model_last_seq + 64'd1;
      if (kind < 5) begin
        fok = 1'b0;
        pok = 1'($urandom_range(0, 1));
        s   = {$urandom, $urandom};
      end else if (kind < 10) begin
        pok = 1'b0;
        s   = {$urandom, $urandom};
      end else if (kind < 60) begin
        s = model_last_seq + 64'd1;
      end else if (kind < 70) begin
        s = model_last_seq + 64'($urandom_range(2, 6));
      end else if (kind < 75) begin
        s = '0;
      end else if (kind < 85) begin
        s = model_last_seq - 64'($urandom_range(0, 3));
      end else begin
        s = {$urandom, $urandom};
      end
      if (tkind < 65) begin
        t = model_last_ns + $signed(NS_PER_MS * 64'($urandom_range(0, 20)));
      end else if (tkind < 78) begin
        t = model_last_ns - $signed(NS_PER_MS * 64'($urandom_range(1, 5)));
      end else if (tkind < 90) begin
        t = model_last_ns + $signed(64'($urandom_range(1, 999999)));
      end else begin
        t = {$urandom, $urandom};
      end
      offer_frame(fok, pok, s, t);
    end
  endtask

  task automatic test_random_traffic();
    send_random_frames(200);
    wait_drained();
    send_steady = 1'b1;
    recv_steady = 1'b1;
    send_random_frames(100);
    wait_drained();
    send_steady = 1'b0;
    recv_steady = 1'b0;
    send_random_frames(200);
    wait_drained();
  endtask

  // Result side: random stall per result, long hold on request
  initial begin
    int hold;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_applied = hold_request;
        hold_request = 0;
      end else begin
        hold = recv_steady ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (result_valid !== 1'b1);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with no prediction waiting, verdict %0d",
                 $time, verdict);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", want.verdict, verdict);
        check_field("session_start", want.session_start, session_start);
        check_field("is_reset", want.is_reset, is_reset);
        check_field("missing_frames", want.missing, missing_frames);
        check_field("not_whole_ms", want.not_whole_ms, not_whole_ms);
        check_field("time_backward", want.backward, time_backward);
        check_field("delivered_count", want.cnt.delivered, delivered_count);
        check_field("stale_count", want.cnt.stale, stale_count);
        check_field("malformed_count", want.cnt.malformed, malformed_count);
        check_field("unverified_count", want.cnt.unverified, unverified_count);
        check_field("reset_count", want.cnt.resets, reset_count);
        check_field("gap_total", want.cnt.gaps, gap_total);
        if (want.verdict == VERDICT_DELIVERED) delivered_seen++;
        if (want.session_start) session_seen++;
        if (want.is_reset) reset_seen++;
        if (want.missing != '0) gap_seen++;
      end
    end
  end

  // Count cycles, note input back-pressure, stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (frame_valid === 1'b1 && frame_stall === 1'b1) input_stall_cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    frame_valid    = 1'b0;
    frame_ok       = 1'b0;
    payload_ok     = 1'b0;
    seq            = '0;
    sample_time_ns = '0;
    model_open     = 1'b0;
    model_last_seq = '0;
    model_last_ns  = '0;
    model_tally    = '0;
    mismatches     = 0;
    frames_sent    = 0;
    results_seen   = 0;
    delivered_seen = 0;
    session_seen   = 0;
    reset_seen     = 0;
    gap_seen       = 0;
    cycles         = 0;
    input_stall_cycles = 0;
    hold_request   = 0;
    hold_applied   = 0;
    send_steady    = 1'b0;
    recv_steady    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_drop_paths();
    test_sequence_order();
    test_wrap_and_limits();
    test_back_pressure();
    test_random_traffic();

    // Let any stray result surface, then flag leftovers
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      mismatches++;
      $display("%0t: %0d predicted results never arrived", $time,
               pending_verdicts.size());
    end

    $display("Run covered %0d frames, %0d results: %0d delivered, %0d session starts,",
             frames_sent, results_seen, delivered_seen, session_seen);
    $display("%0d resets, %0d gaps; output held %0d cycles, input stalled %0d cycles",
             reset_seen, gap_seen, hold_applied, input_stall_cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fst_pkg.sv
rtl/core/frame_sequence_tracker_core.sv
tb/sv/frame_sequence_tracker_core_tb.sv
